FILE: hw/rtl/bti_pkg.sv
package bti_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int STEP_W = $clog2(FRAC_W);
   localparam int ENTRY_W = 2 * DATA_W;
   localparam int PROD_W = FRAC_W + 1 + DATA_W + 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_STEP   = 2'd1,
      OP_LINEAR = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DUP      = 2'd1,
      ST_FULL     = 2'd2,
      ST_FALLBACK = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEL_ZERO     = 2'd0,
      SEL_FALLBACK = 2'd1,
      SEL_PREV     = 2'd2,
      SEL_INTERP   = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic              load_req;
      logic              mem_rd;
      logic [ADDR_W-1:0] rd_addr;
      logic              mem_wr;
      logic [ADDR_W-1:0] wr_addr;
      logic              wr_new;
      logic              take_prev;
      logic              take_next;
      logic              div_init;
      logic              div_step;
      logic              mul;
      logic              add;
      logic              load_rsp;
      res_sel_type       rsp_sel;
      status_type        rsp_status;
      logic              rsp_at_end;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   le;
      logic   dup;
   } sts_type;

endpackage

FILE: hw/rtl/bti_req_if.sv
interface bti_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           operation;
   logic signed [bti_pkg::DATA_W-1:0]    key_time;
   logic signed [bti_pkg::DATA_W-1:0]    entry_value;
   logic signed [bti_pkg::DATA_W-1:0]    fallback_value;

   modport source (output valid, operation, key_time, entry_value, fallback_value,
                   input ready);
   modport sink (input valid, operation, key_time, entry_value, fallback_value,
                 output ready);
endinterface

FILE: hw/rtl/bti_rsp_if.sv
interface bti_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [bti_pkg::DATA_W-1:0] result_value;
   logic                              at_end;
   logic [1:0]                        status;

   modport source (output valid, result_value, at_end, status, input ready);
   modport sink (input valid, result_value, at_end, status, output ready);
endinterface

FILE: hw/rtl/breakpoint_table_interpolator_unit.sv
// Sorted breakpoint table with step and linear lookup. Each request is an
// insert of a (time, value) pair in Q16.16, or a lookup of a query time, and
// each produces exactly one response. One request is worked on at a time. The
// table sits in a single-port-read memory, so the scan reads each entry at
// or below the key and compares it in a separate state. A step lookup, a
// fallback or a rejected insert ends after the scan and the decision, whether
// the scan runs off the end of the table or stops on a later entry. A
// successful insert then moves every later entry up by one, a read and a
// write each, and then writes the new pair. A linear lookup adds bit-serial
// division for the 16-bit fraction, then a multiply and an add. The next
// request is taken the cycle after the response register is loaded. A new
// request is taken while a finished response still waits in the output
// register, but a second finished response waits in the controller until
// the first is taken.
module breakpoint_table_interpolator_unit (
   input logic     clock,
   input logic     reset,
   bti_req_if.sink   req_chan,
   bti_rsp_if.source rsp_chan
);

   bti_pkg::cmd_type cmd;
   bti_pkg::sts_type sts;

   // The controller sequences scan, shift, divide and response handoff.
   bti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the table memory, the neighbor registers, the
   // divider and multiplier, and the response payload register.
   bti_dp u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .req_operation      (req_chan.operation),
      .req_key_time       (req_chan.key_time),
      .req_entry_value    (req_chan.entry_value),
      .req_fallback_value (req_chan.fallback_value),
      .sts                (sts),
      .rsp_result_value   (rsp_chan.result_value),
      .rsp_at_end         (rsp_chan.at_end),
      .rsp_status         (rsp_chan.status)
   );

endmodule

FILE: hw/rtl/bti_ctrl.sv
module bti_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bti_pkg::sts_type  sts,
   output bti_pkg::cmd_type  cmd
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_SCAN   = 11'b00000000010,
      S_CMP    = 11'b00000000100,
      S_DECIDE = 11'b00000001000,
      S_SH_RD  = 11'b00000010000,
      S_SH_WR  = 11'b00000100000,
      S_INS_WR = 11'b00001000000,
      S_DIV    = 11'b00010000000,
      S_MUL    = 11'b00100000000,
      S_ADD    = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [bti_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic [bti_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [bti_pkg::CNT_W-1:0]    shift_ff, shift_in;
   logic [bti_pkg::STEP_W-1:0]   step_ff, step_in;
   bti_pkg::status_type          fin_status_ff, fin_status_in;
   bti_pkg::res_sel_type         fin_sel_ff, fin_sel_in;
   logic                         fin_at_end_ff, fin_at_end_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bti_pkg::CNT_W-1:0]    shift_dec;
   logic                         scan_at_end;

   assign shift_dec = shift_ff - bti_pkg::CNT_W'(1);
   assign scan_at_end = (idx_ff == count_ff) && (count_ff != '0);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      step_in = step_ff;
      fin_status_in = fin_status_ff;
      fin_sel_in = fin_sel_ff;
      fin_at_end_in = fin_at_end_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.rsp_sel = fin_sel_ff;
      cmd.rsp_status = fin_status_ff;
      cmd.rsp_at_end = fin_at_end_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               idx_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = S_DECIDE;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_addr = idx_ff[bti_pkg::ADDR_W-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.le) begin
               cmd.take_prev = 1'b1;
               idx_in = idx_ff + bti_pkg::CNT_W'(1);
               state_in = S_SCAN;
            end else begin
               cmd.take_next = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            fin_at_end_in = scan_at_end;
            fin_sel_in = bti_pkg::SEL_ZERO;
            fin_status_in = bti_pkg::ST_OK;
            state_in = S_DONE;
            case (sts.op)
               bti_pkg::OP_INSERT: begin
                  if ((idx_ff != '0) && sts.dup) begin
                     fin_status_in = bti_pkg::ST_DUP;
                  end else if (count_ff == bti_pkg::CNT_W'(bti_pkg::TABLE_DEPTH)) begin
                     fin_status_in = bti_pkg::ST_FULL;
                  end else begin
                     // The new entry becomes the last one exactly when it lands at the end.
                     fin_at_end_in = (idx_ff == count_ff);
                     shift_in = count_ff;
                     state_in = (count_ff == idx_ff) ? S_INS_WR : S_SH_RD;
                  end
               end
               bti_pkg::OP_STEP, bti_pkg::OP_LINEAR: begin
                  if (idx_ff == '0) begin
                     fin_sel_in = bti_pkg::SEL_FALLBACK;
                     fin_status_in = bti_pkg::ST_FALLBACK;
                  end else if ((sts.op == bti_pkg::OP_STEP) || (idx_ff == count_ff)) begin
                     fin_sel_in = bti_pkg::SEL_PREV;
                  end else begin
                     fin_sel_in = bti_pkg::SEL_INTERP;
                     cmd.div_init = 1'b1;
                     step_in = '0;
                     state_in = S_DIV;
                  end
               end
               default: begin
                  fin_sel_in = bti_pkg::SEL_ZERO;
               end
            endcase
         end
         S_SH_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_addr = shift_dec[bti_pkg::ADDR_W-1:0];
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_addr = shift_ff[bti_pkg::ADDR_W-1:0];
            shift_in = shift_dec;
            state_in = (shift_dec == idx_ff) ? S_INS_WR : S_SH_RD;
         end
         S_INS_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_new = 1'b1;
            cmd.wr_addr = idx_ff[bti_pkg::ADDR_W-1:0];
            count_in = count_ff + bti_pkg::CNT_W'(1);
            state_in = S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + bti_pkg::STEP_W'(1);
            if (step_ff == bti_pkg::STEP_W'(bti_pkg::FRAC_W - 1)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      shift_ff <= shift_in;
      step_ff <= step_in;
      fin_status_ff <= fin_status_in;
      fin_sel_ff <= fin_sel_in;
      fin_at_end_ff <= fin_at_end_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bti_pkg::CNT_W'(bti_pkg::TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SCAN))
      else $error("accepted request did not start a scan");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_WR) |-> (count_ff < bti_pkg::CNT_W'(bti_pkg::TABLE_DEPTH)))
      else $error("insert into a full table");

   a_shift_above: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_WR) |-> (shift_ff > idx_ff))
      else $error("shift moved an entry below the insert position");

endmodule

FILE: hw/rtl/bti_dp.sv
module bti_dp (
   input  logic                              clock,
   input  bti_pkg::cmd_type                  cmd,
   input  logic [1:0]                        req_operation,
   input  logic signed [bti_pkg::DATA_W-1:0] req_key_time,
   input  logic signed [bti_pkg::DATA_W-1:0] req_entry_value,
   input  logic signed [bti_pkg::DATA_W-1:0] req_fallback_value,
   output bti_pkg::sts_type                  sts,
   output logic signed [bti_pkg::DATA_W-1:0] rsp_result_value,
   output logic                              rsp_at_end,
   output logic [1:0]                        rsp_status
);

   logic [bti_pkg::ENTRY_W-1:0]        mem [bti_pkg::TABLE_DEPTH];
   logic [bti_pkg::ENTRY_W-1:0]        rd_ff;
   logic [1:0]                         op_ff;
   logic signed [bti_pkg::DATA_W-1:0]  key_ff, val_ff, fb_ff;
   logic signed [bti_pkg::DATA_W-1:0]  prev_t_ff, prev_v_ff, next_t_ff, next_v_ff;
   logic [bti_pkg::DATA_W-1:0]         rem_ff, den_ff;
   logic [bti_pkg::FRAC_W-1:0]         quot_ff;
   logic signed [bti_pkg::PROD_W-1:0]  prod_ff;
   logic signed [bti_pkg::DATA_W-1:0]  sum_ff;
   logic signed [bti_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                               rsp_at_end_ff;
   logic [1:0]                         rsp_status_ff;
   logic [bti_pkg::DATA_W:0]           rem_dbl, rem_sub;
   logic signed [bti_pkg::DATA_W:0]    val_diff;
   logic signed [bti_pkg::FRAC_W:0]    frac_s;
   logic signed [bti_pkg::DATA_W-1:0]  rd_time;

   assign rd_time = rd_ff[bti_pkg::ENTRY_W-1:bti_pkg::DATA_W];
   assign sts.op = bti_pkg::op_type'(op_ff);
   assign sts.le = (rd_time <= key_ff);
   assign sts.dup = (prev_t_ff == key_ff);

   // Restoring division: the remainder stays below the divisor at every step.
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_sub = rem_dbl - {1'b0, den_ff};
   assign val_diff = {next_v_ff[bti_pkg::DATA_W-1], next_v_ff}
                   - {prev_v_ff[bti_pkg::DATA_W-1], prev_v_ff};
   assign frac_s = {1'b0, quot_ff};

   always_comb begin
      case (cmd.rsp_sel)
         bti_pkg::SEL_FALLBACK: rsp_value_in = fb_ff;
         bti_pkg::SEL_PREV:     rsp_value_in = prev_v_ff;
         bti_pkg::SEL_INTERP:   rsp_value_in = sum_ff;
         default:               rsp_value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_ff <= mem[cmd.rd_addr];
      end
      if (cmd.mem_wr) begin
         mem[cmd.wr_addr] <= cmd.wr_new ? {key_ff, val_ff} : rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_operation;
         key_ff <= req_key_time;
         val_ff <= req_entry_value;
         fb_ff <= req_fallback_value;
      end
      if (cmd.take_prev) begin
         prev_t_ff <= rd_time;
         prev_v_ff <= rd_ff[bti_pkg::DATA_W-1:0];
      end
      if (cmd.take_next) begin
         next_t_ff <= rd_time;
         next_v_ff <= rd_ff[bti_pkg::DATA_W-1:0];
      end
      if (cmd.div_init) begin
         rem_ff <= key_ff - prev_t_ff;
         den_ff <= next_t_ff - prev_t_ff;
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         if (!rem_sub[bti_pkg::DATA_W]) begin
            rem_ff <= rem_sub[bti_pkg::DATA_W-1:0];
            quot_ff <= {quot_ff[bti_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_dbl[bti_pkg::DATA_W-1:0];
            quot_ff <= {quot_ff[bti_pkg::FRAC_W-2:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         prod_ff <= frac_s * val_diff;
      end
      if (cmd.add) begin
         sum_ff <= prev_v_ff
                 + prod_ff[bti_pkg::DATA_W+bti_pkg::FRAC_W-1:bti_pkg::FRAC_W];
      end
      if (cmd.load_rsp) begin
         rsp_value_ff <= rsp_value_in;
         rsp_at_end_ff <= cmd.rsp_at_end;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign rsp_result_value = rsp_value_ff;
   assign rsp_at_end = rsp_at_end_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: verif/bti_tb_if.sv
`timescale 1ns / 1ps

// The testbench connects through the block's own request and response
// interfaces, so this file holds no further definitions.

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// Testbench for the breakpoint table interpolator. A driver process feeds
// requests from a queue that the stimulus block fills, and a monitor process
// compares every response with a prediction worked out when the request was
// accepted.
module testbench;

   typedef struct {
      bti_pkg::op_type    op;
      logic signed [31:0] key;
      logic signed [31:0] val;
      logic signed [31:0] fb;
   } request_type;

   typedef struct {
      logic signed [31:0]   value;
      logic                 at_end;
      bti_pkg::status_type  status;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bti_req_if req_chan ();
   bti_rsp_if rsp_chan ();

   breakpoint_table_interpolator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #6 clock = ~clock;

   // The predictor's own copy of the table.
   logic signed [31:0] bp_time [bti_pkg::TABLE_DEPTH];
   logic signed [31:0] bp_value [bti_pkg::TABLE_DEPTH];
   int                 bp_count = 0;

   request_type  pending_requests [$];
   response_type expected_responses [$];

   int  mismatch_count;
   int  response_count;
   int  hold_off_cycles;
   bit  hold_off_go = 1'b0;
   bit  hold_off_seen;
   bit  allow_idle = 1'b1;
   int  status_seen [4];
   int  op_seen [4];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      begin
         $display("MISMATCH response %0d %s: got %0d, expected %0d",
                  response_count, what, got, want);
         mismatch_count++;
      end
   endtask

   // Applies one request to the predicted table and returns its response.
   function automatic response_type predict_response(input request_type r);
      response_type      rsp;
      int                pos;
      int                n;
      longint            t0, t1, v0, v1, num, den, frac, prod;
      begin
         rsp.value = '0;
         rsp.status = bti_pkg::ST_OK;
         if (r.op == bti_pkg::OP_INSERT) begin
            pos = 0;
            while (pos < bp_count && bp_time[pos] < r.key) pos++;
            if (pos < bp_count && bp_time[pos] == r.key) begin
               rsp.status = bti_pkg::ST_DUP;
            end else if (bp_count >= bti_pkg::TABLE_DEPTH) begin
               rsp.status = bti_pkg::ST_FULL;
            end else begin
               for (int i = bp_count; i > pos; i--) begin
                  bp_time[i] = bp_time[i-1];
                  bp_value[i] = bp_value[i-1];
               end
               bp_time[pos] = r.key;
               bp_value[pos] = r.val;
               bp_count++;
            end
         end else if (r.op == bti_pkg::OP_STEP || r.op == bti_pkg::OP_LINEAR) begin
            n = 0;
            while (n < bp_count && bp_time[n] <= r.key) n++;
            if (n == 0) begin
               rsp.value = r.fb;
               rsp.status = bti_pkg::ST_FALLBACK;
            end else if (r.op == bti_pkg::OP_STEP || n == bp_count) begin
               rsp.value = bp_value[n-1];
            end else begin
               t0 = bp_time[n-1];
               t1 = bp_time[n];
               v0 = bp_value[n-1];
               v1 = bp_value[n];
               num = (longint'(r.key) - t0) <<< 16;
               den = t1 - t0;
               frac = (num / den) & 64'hFFFF;
               prod = frac * (v1 - v0);
               // Floor division by 65536 is an arithmetic shift.
               rsp.value = 32'(v0 + (prod >>> 16));
            end
         end
         rsp.at_end = (bp_count > 0 && bp_time[bp_count-1] <= r.key);
         return rsp;
      end
   endfunction

   // Driver: the queue head is the request on offer. It is popped once
   // accepted, and the new head is offered unless this cycle idles.
   always @(posedge clock) begin
      request_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            void'(pending_requests.pop_front());
         end
         if (pending_requests.size() > 0
               && !(allow_idle && $urandom_range(99) < 34)) begin
            nxt = pending_requests[0];
            req_chan.valid <= 1'b1;
            req_chan.operation <= nxt.op;
            req_chan.key_time <= nxt.key;
            req_chan.entry_value <= nxt.val;
            req_chan.fallback_value <= nxt.fb;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Predicts at acceptance, so the table copy tracks the block in order.
   always @(posedge clock) begin
      request_type acc;
      if (!reset && req_chan.valid && req_chan.ready) begin
         acc.op = bti_pkg::op_type'(req_chan.operation);
         acc.key = req_chan.key_time;
         acc.val = req_chan.entry_value;
         acc.fb = req_chan.fallback_value;
         op_seen[acc.op]++;
         expected_responses.push_back(predict_response(acc));
      end
   end

   // Counts a long receiver hold-off each time the stimulus asks for one.
   always @(posedge clock) begin
      if (reset) begin
         hold_off_cycles <= 0;
         hold_off_seen <= 1'b0;
      end else if (hold_off_go != hold_off_seen) begin
         hold_off_seen <= hold_off_go;
         hold_off_cycles <= 600;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
      end
   end

   // Monitor and response stalls. A running hold-off keeps ready low.
   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_chan.result_value !== want.value)
                  report_mismatch("result_value", rsp_chan.result_value, want.value);
               if (rsp_chan.at_end !== want.at_end)
                  report_mismatch("at_end", rsp_chan.at_end, want.at_end);
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", rsp_chan.status, want.status);
               status_seen[want.status]++;
            end
            response_count++;
         end
         if (hold_off_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(allow_idle && $urandom_range(99) < 34);
         end
      end
   end

   task automatic queue_request(input bti_pkg::op_type op, input logic [31:0] key,
                                input logic [31:0] val, input logic [31:0] fb);
      request_type r;
      begin
         r.op = op;
         r.key = key;
         r.val = val;
         r.fb = fb;
         pending_requests.push_back(r);
      end
   endtask

   task automatic wait_drained;
      begin
         while (pending_requests.size() != 0 || req_chan.valid
                || expected_responses.size() != 0)
            @(posedge clock);
      end
   endtask

   // Picks a key near the ones already in the table so duplicates and
   // in-between queries happen often.
   function automatic logic [31:0] pick_key();
      int k;
      begin
         k = $urandom_range(9);
         if (k < 3 && bp_count > 0) return bp_time[$urandom_range(bp_count-1)];
         if (k < 6 && bp_count > 0)
            return 32'(bp_time[$urandom_range(bp_count-1)]
                       + $urandom_range(200000) - 100000);
         if (k == 6) return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         return $urandom;
      end
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, every operation, the unused code.
      queue_request(bti_pkg::OP_STEP, 32'h0, 32'h0, 32'h7FFF_FFFF);
      queue_request(bti_pkg::OP_LINEAR, 32'h8000_0000, 32'h0, 32'h8000_0000);
      queue_request(bti_pkg::OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(bti_pkg::OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      queue_request(bti_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      queue_request(bti_pkg::OP_LINEAR, 32'h0, 32'h0, 32'h0);
      queue_request(bti_pkg::OP_LINEAR, 32'h7FFF_FFFE, 32'h0, 32'h0);
      queue_request(bti_pkg::OP_STEP, 32'h7FFF_FFFF, 32'h0, 32'h0);
      queue_request(bti_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h1, 32'h0);
      queue_request(bti_pkg::OP_INSERT, 32'h0001_0000, 32'h0005_0000, 32'h0);
      queue_request(bti_pkg::OP_LINEAR, 32'h0000_8000, 32'h0, 32'h0);
      queue_request(bti_pkg::OP_LINEAR, 32'h0001_8000, 32'h0, 32'h0);
      queue_request(bti_pkg::OP_UNUSED, 32'h7FFF_FFFF, 32'h0, 32'h0);
      for (int i = 0; i < 14; i++)
         queue_request(bti_pkg::OP_INSERT, 32'h0002_0000 + i * 32'h100,
                       32'(i * 77777 - 500000), 0);
      queue_request(bti_pkg::OP_INSERT, 32'h0000_0005, 32'h0, 32'h0);
      queue_request(bti_pkg::OP_LINEAR, 32'h0002_0080, 32'h0, 32'h0);
      queue_request(bti_pkg::OP_STEP, 32'h8000_0000, 32'h0, 32'h1234_5678);
      wait_drained();

      // The sender has paused until everything came back; now the receiver
      // stalls for a long stretch while requests keep coming.
      hold_off_go = ~hold_off_go;
      for (int i = 0; i < 20; i++)
         queue_request(bti_pkg::op_type'($urandom_range(2)), $urandom, $urandom, $urandom);
      wait_drained();

      // Random phases. The table cannot be cleared without reset, so most
      // lookups hit a full table; early inserts still exercise duplicates.
      for (int i = 0; i < 350; i++) begin
         if (i == 120) allow_idle = 1'b0;
         if (i == 220) allow_idle = 1'b1;
         queue_request(bti_pkg::op_type'($urandom_range(9) < 2 ? 0 : $urandom_range(3)),
                       pick_key(), $urandom, $urandom);
         if (pending_requests.size() > 8) begin
            while (pending_requests.size() > 4) @(posedge clock);
         end
      end
      wait_drained();
      repeat (80) @(posedge clock);

      $display("Run covered %0d responses: inserts %0d, step %0d, linear %0d, unused %0d.",
               response_count, op_seen[bti_pkg::OP_INSERT], op_seen[bti_pkg::OP_STEP],
               op_seen[bti_pkg::OP_LINEAR], op_seen[bti_pkg::OP_UNUSED]);
      $display("Status counts ok %0d, duplicate %0d, full %0d, fallback %0d.",
               status_seen[bti_pkg::ST_OK], status_seen[bti_pkg::ST_DUP],
               status_seen[bti_pkg::ST_FULL], status_seen[bti_pkg::ST_FALLBACK]);
      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d responses outstanding.", expected_responses.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/bti_pkg.sv
hw/rtl/bti_req_if.sv
hw/rtl/bti_rsp_if.sv
hw/rtl/bti_ctrl.sv
hw/rtl/bti_dp.sv
hw/rtl/breakpoint_table_interpolator_unit.sv
verif/bti_tb_if.sv
verif/testbench.sv
